[rtl/core/ttip_pkg.sv]
package ttip_pkg;

  // Parser phases
  typedef logic [2:0] phase_t;
  localparam phase_t PH_START  = 3'd0;
  localparam phase_t PH_FIRST  = 3'd1;
  localparam phase_t PH_ZERO   = 3'd2;
  localparam phase_t PH_ZEROX  = 3'd3;
  localparam phase_t PH_ZERO16 = 3'd4;
  localparam phase_t PH_DIGITS = 3'd5;
  localparam phase_t PH_NL     = 3'd6;
  localparam phase_t PH_DRAIN  = 3'd7;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_INVAL = 2'd1;
  localparam status_t ST_RANGE = 2'd2;

  // Result kinds
  typedef logic [2:0] kind_t;
  localparam kind_t KIND_U64   = 3'd0;
  localparam kind_t KIND_S64   = 3'd1;
  localparam kind_t KIND_ULONG = 3'd2;
  localparam kind_t KIND_SLONG = 3'd3;
  localparam kind_t KIND_U32   = 3'd4;
  localparam kind_t KIND_S32   = 3'd5;

  // Register map: one bit of paddr selects the register
  localparam logic REG_RADIX = 1'b0;
  localparam logic REG_KIND  = 1'b1;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  // Digit value 0..15, or 16 when the character is no digit.
  localparam logic [4:0] NO_DIGIT = 5'd16;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    to_lower = (c >= CH_UA && c <= CH_UZ) ? c + 8'h20 : c;
  endfunction

  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [7:0] l;
    l = to_lower(c);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      digit_of = 5'(c - CH_ZERO);
    end else if (l >= CH_LA && l <= CH_LF) begin
      digit_of = 5'(l - CH_LA) + 5'd10;
    end else begin
      digit_of = NO_DIGIT;
    end
  endfunction

endpackage

[rtl/core/text_to_integer_parser.sv]
// The result of a string is registered into the result buffer when its NUL word is taken.
// Throughput: one character word per cycle while ch_stall is low; each word passes
// through one step of combinational logic (digit decode, multiply by the base and add)
// into the state registers. A two-entry result buffer keeps input flowing while one
// result waits to be taken. Reset (rst, synchronous, active high) clears the parser
// state, radix and result_kind, and empties the result buffer.
module text_to_integer_parser #(
  parameter int LONG_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Character input
  input  logic        ch_valid,
  output logic        ch_stall,
  input  logic [7:0]  ch,
  // Result output
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  status,
  output logic [63:0] value,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers
  logic [4:0]            radix;
  ttip_pkg::kind_t       result_kind;

  // Parser state
  ttip_pkg::phase_t      phase, phase_next;
  logic [63:0]           accum, accum_next;
  logic [4:0]            eff_base, eff_base_next;
  logic                  negative, negative_next;
  logic                  seen_digit, seen_digit_next;
  logic                  overflowed, overflowed_next;

  // Result buffer: main slot and skid slot
  ttip_pkg::status_t     skid_status;
  logic [63:0]           skid_value;
  logic                  skid_valid;

  logic                  ch_take;
  logic                  emit;
  logic                  do_finish;
  ttip_pkg::status_t     emit_status;
  ttip_pkg::status_t     fin_status;
  logic [63:0]           fin_value;
  ttip_pkg::status_t     new_status;
  logic [63:0]           new_value;
  logic [7:0]            lc;
  logic [4:0]            dig;
  logic                  is_signed;
  logic                  plus_ok;
  logic                  cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign ch_stall = skid_valid;
  assign ch_take  = ch_valid && !ch_stall;

  always_comb begin
    prdata = '0;
    if (paddr[2] == ttip_pkg::REG_RADIX) begin
      prdata[4:0] = radix;
    end else begin
      prdata[2:0] = result_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix       <= '0;
      result_kind <= ttip_pkg::KIND_U64;
    end else if (cfg_wr) begin
      if (paddr[2] == ttip_pkg::REG_RADIX) begin
        radix <= pwdata[4:0];
      end else begin
        result_kind <= pwdata[2:0];
      end
    end
  end

  assign lc  = ttip_pkg::to_lower(ch);
  assign dig = ttip_pkg::digit_of(ch);
  assign is_signed = (result_kind == ttip_pkg::KIND_S64) ||
                     (result_kind == ttip_pkg::KIND_SLONG) ||
                     (result_kind == ttip_pkg::KIND_S32);
  assign plus_ok   = (result_kind != ttip_pkg::KIND_ULONG) &&
                     (result_kind != ttip_pkg::KIND_U32);

  // One character step. The phases fall through in order, as a word may settle the
  // prefix and then count as the first digit in the same cycle.
  always_comb begin
    logic done;
    done            = 1'b0;
    phase_next      = phase;
    accum_next      = accum;
    eff_base_next   = eff_base;
    negative_next   = negative;
    seen_digit_next = seen_digit;
    overflowed_next = overflowed;
    emit            = 1'b0;
    do_finish       = 1'b0;
    emit_status     = ttip_pkg::ST_INVAL;

    if (phase_next == ttip_pkg::PH_START) begin
      phase_next = ttip_pkg::PH_FIRST;
      if (is_signed && ch == ttip_pkg::CH_MINUS) begin
        negative_next = 1'b1;
        done          = 1'b1;
      end else if (plus_ok && ch == ttip_pkg::CH_PLUS) begin
        done = 1'b1;
      end
    end

    if (!done && phase_next == ttip_pkg::PH_FIRST) begin
      if (ch == ttip_pkg::CH_NUL) begin
        emit = 1'b1;
        done = 1'b1;
      end else if (radix == 5'd0) begin
        if (ch == ttip_pkg::CH_ZERO) begin
          phase_next = ttip_pkg::PH_ZERO;
          done       = 1'b1;
        end else begin
          eff_base_next = 5'd10;
          phase_next    = ttip_pkg::PH_DIGITS;
        end
      end else if (radix == 5'd16 && ch == ttip_pkg::CH_ZERO) begin
        phase_next = ttip_pkg::PH_ZERO16;
        done       = 1'b1;
      end else begin
        eff_base_next = radix;
        phase_next    = ttip_pkg::PH_DIGITS;
      end
    end

    if (!done && phase_next == ttip_pkg::PH_ZERO) begin
      if (lc == ttip_pkg::CH_LX) begin
        phase_next = ttip_pkg::PH_ZEROX;
        done       = 1'b1;
      end else begin
        eff_base_next   = 5'd8;
        accum_next      = '0;
        seen_digit_next = 1'b1;
        phase_next      = ttip_pkg::PH_DIGITS;
      end
    end

    if (!done && phase_next == ttip_pkg::PH_ZEROX) begin
      if (dig != ttip_pkg::NO_DIGIT) begin
        eff_base_next = 5'd16;
        phase_next    = ttip_pkg::PH_DIGITS;
      end else begin
        // An octal zero followed by 'x' is trailing garbage.
        eff_base_next   = 5'd8;
        seen_digit_next = 1'b1;
        if (ch == ttip_pkg::CH_NUL) begin
          emit = 1'b1;
        end else begin
          phase_next = ttip_pkg::PH_DRAIN;
        end
        done = 1'b1;
      end
    end

    if (!done && phase_next == ttip_pkg::PH_ZERO16) begin
      eff_base_next = 5'd16;
      phase_next    = ttip_pkg::PH_DIGITS;
      if (lc == ttip_pkg::CH_LX) begin
        done = 1'b1;
      end else begin
        accum_next      = '0;
        seen_digit_next = 1'b1;
      end
    end

    if (!done && phase_next == ttip_pkg::PH_DIGITS) begin
      done = 1'b1;
      if (dig != ttip_pkg::NO_DIGIT && dig < eff_base_next) begin
        if (|accum_next[63:59]) begin
          accum_next      = '1;
          overflowed_next = 1'b1;
          phase_next      = ttip_pkg::PH_DRAIN;
        end else begin
          accum_next      = accum_next * 64'(eff_base_next) + 64'(dig);
          seen_digit_next = 1'b1;
        end
      end else if (!seen_digit_next) begin
        if (ch == ttip_pkg::CH_NUL) begin
          emit = 1'b1;
        end else begin
          phase_next = ttip_pkg::PH_DRAIN;
        end
      end else if (ch == ttip_pkg::CH_NUL) begin
        emit      = 1'b1;
        do_finish = 1'b1;
      end else if (ch == ttip_pkg::CH_NL) begin
        phase_next = ttip_pkg::PH_NL;
      end else begin
        phase_next = ttip_pkg::PH_DRAIN;
      end
    end

    if (!done && phase_next == ttip_pkg::PH_NL) begin
      done = 1'b1;
      if (ch == ttip_pkg::CH_NUL) begin
        emit      = 1'b1;
        do_finish = 1'b1;
      end else begin
        phase_next = ttip_pkg::PH_DRAIN;
      end
    end

    if (!done) begin
      if (ch == ttip_pkg::CH_NUL) begin
        emit        = 1'b1;
        emit_status = overflowed_next ? ttip_pkg::ST_RANGE : ttip_pkg::ST_INVAL;
      end else begin
        phase_next = ttip_pkg::PH_DRAIN;
      end
    end

    // Every NUL starts the next string from scratch.
    if (emit) begin
      phase_next      = ttip_pkg::PH_START;
      accum_next      = '0;
      eff_base_next   = '0;
      negative_next   = 1'b0;
      seen_digit_next = 1'b0;
      overflowed_next = 1'b0;
    end
  end

  // Range check of the finished value for the selected kind. The finish path only
  // runs from the digit or newline phase, where the value is the stored accumulator.
  always_comb begin
    logic [63:0] u;
    logic [63:0] s;
    u          = accum;
    s          = u;
    fin_status = ttip_pkg::ST_OK;
    case (result_kind)
      ttip_pkg::KIND_ULONG: begin
        if ((u >> LONG_BITS) != 64'd0) fin_status = ttip_pkg::ST_RANGE;
      end
      ttip_pkg::KIND_U32: begin
        if (u[63:32] != 32'd0) fin_status = ttip_pkg::ST_RANGE;
      end
      ttip_pkg::KIND_S64, ttip_pkg::KIND_SLONG, ttip_pkg::KIND_S32: begin
        if (negative) begin
          s = 64'd0 - u;
          if (s != 64'd0 && !s[63]) fin_status = ttip_pkg::ST_RANGE;
        end else if (u[63]) begin
          fin_status = ttip_pkg::ST_RANGE;
        end
        if (result_kind == ttip_pkg::KIND_SLONG) begin
          if (($signed(s) >>> (LONG_BITS - 1)) != 64'sd0 &&
              ($signed(s) >>> (LONG_BITS - 1)) != -64'sd1) begin
            fin_status = ttip_pkg::ST_RANGE;
          end
        end
        if (result_kind == ttip_pkg::KIND_S32) begin
          if (s[63:31] != '0 && s[63:31] != '1) fin_status = ttip_pkg::ST_RANGE;
        end
      end
      default: begin
        fin_status = ttip_pkg::ST_OK;
      end
    endcase
    fin_value = s;
  end

  always_comb begin
    new_status = do_finish ? fin_status : emit_status;
    new_value  = (do_finish && fin_status == ttip_pkg::ST_OK) ? fin_value : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= ttip_pkg::PH_START;
      accum      <= '0;
      eff_base   <= '0;
      negative   <= 1'b0;
      seen_digit <= 1'b0;
      overflowed <= 1'b0;
    end else if (ch_take) begin
      phase      <= phase_next;
      accum      <= accum_next;
      eff_base   <= eff_base_next;
      negative   <= negative_next;
      seen_digit <= seen_digit_next;
      overflowed <= overflowed_next;
    end
  end

  // Result buffer. The input stalls only while the skid slot holds a word.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= ch_take && emit;
      end
    end else if (ch_take && emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || !res_stall) begin
      if (skid_valid) begin
        status <= skid_status;
        value  <= skid_value;
      end else begin
        status <= new_status;
        value  <= new_value;
      end
    end else if (ch_take && emit) begin
      skid_status <= new_status;
      skid_value  <= new_value;
    end
  end

  // A full skid slot always sits behind a valid main slot.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid slot full while main slot empty");

  // The skid slot fills only when the main slot is held.
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(res_valid && res_stall))
    else $error("skid slot filled while main slot was free");

  // Failed conversions carry a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status != ttip_pkg::ST_OK) |-> (value == 64'd0))
    else $error("nonzero value with error status");

  // No stored status is outside the defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (status == ttip_pkg::ST_OK || status == ttip_pkg::ST_INVAL ||
                   status == ttip_pkg::ST_RANGE))
    else $error("undefined status code");

endmodule
